[src/rctv_pkg.sv]
// ----------------------------------------------------------------------------
// rctv_pkg
// types and constants shared by the voxel ray caster and its channels
// ----------------------------------------------------------------------------
package rctv_pkg;

    localparam int CFG_DATA_W = 34;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_VOXEL_SHIFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE_SQ  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIE_TOLERANCE = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    localparam logic [1:0] CELL_UNKNOWN = 2'd0;

    typedef logic [2:0] t_status;
    localparam t_status ST_TARGET   = 3'd0;
    localparam t_status ST_OCCUPIED = 3'd1;
    localparam t_status ST_UNKNOWN  = 3'd2;
    localparam t_status ST_RANGE    = 3'd3;
    localparam t_status ST_EDGE     = 3'd4;
    localparam t_status ST_ZERO_DIR = 3'd5;
    localparam t_status ST_OUTSIDE  = 3'd6;
    localparam t_status ST_WRITE    = 3'd7;

    localparam logic [3:0]  SHIFT_LIMIT = 4'd10;
    localparam int          NUM_W       = 33;
    localparam int          DIV_CNT_W   = 6;
    localparam logic [31:0] TIME_SAT    = 32'hFFFF_FFFF;
    localparam logic [33:0] TIME_OFF    = 34'h2_0000_0000;

    typedef struct packed {
        logic               action;
        logic [5:0]         cell_x;
        logic [5:0]         cell_y;
        logic [5:0]         cell_z;
        logic [1:0]         cell_state;
        logic [15:0]        origin_x;
        logic [15:0]        origin_y;
        logic [15:0]        origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic               pass_unknown;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic [5:0] end_x;
        logic [5:0] end_y;
        logic [5:0] end_z;
    } t_rsp;

endpackage

[src/rctv_req_if.sv]
// ----------------------------------------------------------------------------
// rctv_req_if
// request channel: valid/ready with one write or cast item
// ----------------------------------------------------------------------------
interface rctv_req_if;
    import rctv_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/rctv_rsp_if.sv]
// ----------------------------------------------------------------------------
// rctv_rsp_if
// response channel: valid/ready with one status and end voxel
// ----------------------------------------------------------------------------
interface rctv_rsp_if;
    import rctv_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/ray_cast_to_target_voxel.sv]
// ----------------------------------------------------------------------------
// ray_cast_to_target_voxel
// dense voxel grid with voxel writes and 3d dda ray casts toward a target
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  i_req     in         valid/ready    write or cast transaction (t_req)
//  o_rsp     out        valid/ready    status and end voxel (t_rsp)
//  i_cfg_*   in         write enable   register index and data
//
//  after reset the grid is swept to unknown, one entry per cycle, with i_req
//  held not ready; config writes still land. a write goes from idle straight
//  to the emit state. a cast does the origin lookup, runs the six parallel
//  bit-serial restoring dividers (face and step time per axis), then steps
//  voxel by voxel (memory read, then test) and hands off in the emit state.
//  one transaction is in flight; a finished response waits in the output
//  register, and the engine only holds when that register is still full.
// ----------------------------------------------------------------------------
module ray_cast_to_target_voxel #(
    parameter int GRID_SIZE = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rctv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rctv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rctv_req_if.sink                       i_req,
    rctv_rsp_if.source                     o_rsp
);
    import rctv_pkg::*;

    localparam int KW    = $clog2(GRID_SIZE);
    localparam int DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = ((KW + 11 > 17) ? KW + 11 : 17) + 1;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW + 2;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ORG, S_DIV, S_STEP, S_CHECK, S_EMIT
    } t_state;

    function automatic logic [AW-1:0] addr_of(input logic [KW-1:0] kx,
                                              input logic [KW-1:0] ky,
                                              input logic [KW-1:0] kz);
        return AW'(kz) * AW'(GRID_SIZE * GRID_SIZE) + AW'(ky) * AW'(GRID_SIZE)
               + AW'(kx);
    endfunction

    function automatic t_rsp mk_rsp(input t_status st, input logic [KW-1:0] kx,
                                    input logic [KW-1:0] ky,
                                    input logic [KW-1:0] kz);
        t_rsp r;
        r.status = st;
        r.end_x  = 6'(kx);
        r.end_y  = 6'(ky);
        r.end_z  = 6'(kz);
        return r;
    endfunction

    // one restoring step: returns {remainder, quotient/numerator shift}
    function automatic logic [16+NUM_W-1:0] div_step(input logic [15:0] rem,
                                                     input logic [NUM_W-1:0] q,
                                                     input logic [15:0] d);
        logic [16:0] t;
        logic [15:0] nr;
        logic        b;
        t = {rem, q[NUM_W-1]};
        if (t >= {1'b0, d}) begin
            nr = 16'(t - {1'b0, d});
            b  = 1'b1;
        end else begin
            nr = t[15:0];
            b  = 1'b0;
        end
        return {nr, q[NUM_W-2:0], b};
    endfunction

    function automatic logic [31:0] sat32(input logic [NUM_W-1:0] q);
        return q[NUM_W-1] ? TIME_SAT : q[31:0];
    endfunction

    // config
    logic [3:0]            r_voxel_shift;
    logic [33:0]           r_max_range_sq;
    logic [7:0]            r_tie_tol;

    // control
    t_state                r_state;
    logic [AW-1:0]         r_clr;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_out_valid;

    // per-cast payload
    logic [15:0]           r_org [3];
    logic [KW-1:0]         r_key [3];
    logic [5:0]            r_tgt [3];
    logic                  r_neg [3];
    logic [15:0]           r_ad  [3];
    logic                  r_ign;
    logic                  r_outside;
    logic [33:0]           r_tmax [3];
    logic [31:0]           r_tdel [3];
    logic [NUM_W-1:0]      r_qm [3];
    logic [NUM_W-1:0]      r_qd [3];
    logic [15:0]           r_rm [3];
    logic [15:0]           r_rdv [3];
    logic [PW-1:0]         r_sq [3];
    t_rsp                  r_pend;
    t_rsp                  r_out;

    // grid memory
    logic [1:0]            mem [DEPTH];
    logic [1:0]            r_rd;

    logic [3:0]            s;
    logic [15:0]           in_org [3];
    logic signed [15:0]    in_dir [3];
    logic [5:0]            in_cell [3];
    logic [15:0]           okey [3];
    logic                  in_range;
    logic                  acc;
    logic                  wr_en;
    logic [AW-1:0]         waddr;
    logic [1:0]            wdata;
    logic [AW-1:0]         raddr;
    logic [DW-1:0]         face_gap [3];
    logic [1:0]            dim;
    logic                  at_edge;
    logic [KW-1:0]         nkey [3];
    logic [33:0]           tsum;
    logic signed [DW-1:0]  d2 [3];
    logic [SW-1:0]         sqsum;
    logic                  range_hit;
    logic                  hit_tgt;
    logic                  dir_zero;
    logic                  slot_free;

    assign s = (r_voxel_shift > SHIFT_LIMIT) ? SHIFT_LIMIT : r_voxel_shift;

    assign in_org[0]  = i_req.data.origin_x;
    assign in_org[1]  = i_req.data.origin_y;
    assign in_org[2]  = i_req.data.origin_z;
    assign in_dir[0]  = i_req.data.dir_x;
    assign in_dir[1]  = i_req.data.dir_y;
    assign in_dir[2]  = i_req.data.dir_z;
    assign in_cell[0] = i_req.data.cell_x;
    assign in_cell[1] = i_req.data.cell_y;
    assign in_cell[2] = i_req.data.cell_z;

    assign acc       = i_req.valid && (r_state == S_IDLE);
    assign in_range  = (int'(in_cell[0]) < GRID_SIZE) && (int'(in_cell[1]) < GRID_SIZE)
                       && (int'(in_cell[2]) < GRID_SIZE);
    assign slot_free = !r_out_valid || o_rsp.ready;
    assign dir_zero  = (r_ad[0] == 16'd0) && (r_ad[1] == 16'd0) && (r_ad[2] == 16'd0);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            okey[a] = in_org[a] >> s;
            if (r_neg[a]) begin
                face_gap[a] = DW'(r_org[a]) - (DW'(r_key[a]) << s);
            end else begin
                face_gap[a] = ((DW'(r_key[a]) + DW'(1)) << s) - DW'(r_org[a]);
            end
        end
    end

    // axis choice and next voxel
    always_comb begin
        logic [33:0] a0;
        logic [33:0] a1;
        a0 = r_tmax[0] + 34'(r_tie_tol);
        a1 = r_tmax[1] + 34'(r_tie_tol);
        if (a0 < r_tmax[1]) begin
            dim = (a0 < r_tmax[2]) ? 2'd0 : 2'd2;
        end else begin
            dim = (a1 < r_tmax[2]) ? 2'd1 : 2'd2;
        end
        at_edge = r_neg[dim] ? (r_key[dim] == '0)
                             : (r_key[dim] == KW'(GRID_SIZE - 1));
        for (int a = 0; a < 3; a++) begin
            nkey[a] = r_key[a];
        end
        nkey[dim] = r_neg[dim] ? r_key[dim] - KW'(1) : r_key[dim] + KW'(1);
        tsum = r_tmax[dim] + 34'(r_tdel[dim]);
        for (int a = 0; a < 3; a++) begin
            d2[a] = $signed((DW'({nkey[a], 1'b1}) << s) - DW'({r_org[a], 1'b0}));
        end
    end

    assign sqsum     = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    assign range_hit = (r_max_range_sq != 34'd0) && (sqsum > SW'({r_max_range_sq, 2'b00}));
    assign hit_tgt   = (16'(r_key[0]) == 16'(r_tgt[0])) && (16'(r_key[1]) == 16'(r_tgt[1]))
                       && (16'(r_key[2]) == 16'(r_tgt[2]));

    // memory ports
    always_comb begin
        wr_en = 1'b0;
        waddr = r_clr;
        wdata = CELL_UNKNOWN;
        if (r_state == S_CLEAR) begin
            wr_en = 1'b1;
        end else if (acc && (i_req.data.action == ACT_WRITE) && in_range) begin
            wr_en = 1'b1;
            waddr = addr_of(KW'(in_cell[0]), KW'(in_cell[1]), KW'(in_cell[2]));
            wdata = i_req.data.cell_state;
        end
        if (r_state == S_IDLE) begin
            raddr = addr_of(KW'(okey[0]), KW'(okey[1]), KW'(okey[2]));
        end else begin
            raddr = addr_of(nkey[0], nkey[1], nkey[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[raddr];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voxel_shift  <= SHIFT_LIMIT;
            r_max_range_sq <= 34'd0;
            r_tie_tol      <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VOXEL_SHIFT:   r_voxel_shift  <= i_cfg_data[3:0];
                CFG_MAX_RANGE_SQ:  r_max_range_sq <= i_cfg_data[33:0];
                CFG_TIE_TOLERANCE: r_tie_tol      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the emit state refills the output register itself
            if (o_rsp.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        if (i_req.data.action == ACT_WRITE) begin
                            r_pend.status <= ST_WRITE;
                            r_pend.end_x  <= i_req.data.cell_x;
                            r_pend.end_y  <= i_req.data.cell_y;
                            r_pend.end_z  <= i_req.data.cell_z;
                            r_state       <= S_EMIT;
                        end else begin
                            for (int a = 0; a < 3; a++) begin
                                r_org[a] <= in_org[a];
                                r_key[a] <= KW'(okey[a]);
                                r_tgt[a] <= in_cell[a];
                                r_neg[a] <= in_dir[a][15];
                                r_ad[a]  <= in_dir[a][15] ? 16'(~in_dir[a] + 16'sd1)
                                                          : 16'(in_dir[a]);
                            end
                            r_ign     <= i_req.data.pass_unknown;
                            r_outside <= (int'(okey[0]) >= GRID_SIZE)
                                         || (int'(okey[1]) >= GRID_SIZE)
                                         || (int'(okey[2]) >= GRID_SIZE);
                            r_state   <= S_ORG;
                        end
                    end
                end
                S_ORG: begin
                    priority if (r_outside) begin
                        r_pend  <= mk_rsp(ST_OUTSIDE, '0, '0, '0);
                        r_state <= S_EMIT;
                    end else if (hit_tgt) begin
                        r_pend  <= mk_rsp(ST_TARGET, r_key[0], r_key[1], r_key[2]);
                        r_state <= S_EMIT;
                    end else if (r_rd[1]) begin
                        r_pend  <= mk_rsp(ST_OCCUPIED, r_key[0], r_key[1], r_key[2]);
                        r_state <= S_EMIT;
                    end else if (r_rd == CELL_UNKNOWN && !r_ign) begin
                        r_pend  <= mk_rsp(ST_UNKNOWN, r_key[0], r_key[1], r_key[2]);
                        r_state <= S_EMIT;
                    end else if (dir_zero) begin
                        r_pend  <= mk_rsp(ST_ZERO_DIR, r_key[0], r_key[1], r_key[2]);
                        r_state <= S_EMIT;
                    end else begin
                        for (int a = 0; a < 3; a++) begin
                            r_qm[a]  <= {face_gap[a][10:0], 22'd0};
                            r_qd[a]  <= NUM_W'(1) << (6'(s) + 6'd22);
                            r_rm[a]  <= '0;
                            r_rdv[a] <= '0;
                        end
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == DIV_CNT_W'(NUM_W)) begin
                        for (int a = 0; a < 3; a++) begin
                            if (r_ad[a] == 16'd0) begin
                                r_tmax[a] <= TIME_OFF;
                                r_tdel[a] <= '0;
                            end else begin
                                r_tmax[a] <= 34'(sat32(r_qm[a]));
                                r_tdel[a] <= sat32(r_qd[a]);
                            end
                        end
                        r_state <= S_STEP;
                    end else begin
                        for (int a = 0; a < 3; a++) begin
                            {r_rm[a], r_qm[a]}  <= div_step(r_rm[a], r_qm[a], r_ad[a]);
                            {r_rdv[a], r_qd[a]} <= div_step(r_rdv[a], r_qd[a], r_ad[a]);
                        end
                        r_cnt <= r_cnt + DIV_CNT_W'(1);
                    end
                end
                S_STEP: begin
                    if (at_edge) begin
                        r_pend  <= mk_rsp(ST_EDGE, r_key[0], r_key[1], r_key[2]);
                        r_state <= S_EMIT;
                    end else begin
                        for (int a = 0; a < 3; a++) begin
                            r_key[a] <= nkey[a];
                            r_sq[a]  <= PW'(d2[a] * d2[a]);
                        end
                        r_tmax[dim] <= (tsum > 34'(TIME_SAT)) ? 34'(TIME_SAT) : tsum;
                        r_state     <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    priority if (range_hit) begin
                        r_pend  <= mk_rsp(ST_RANGE, r_key[0], r_key[1], r_key[2]);
                        r_state <= S_EMIT;
                    end else if (hit_tgt) begin
                        r_pend  <= mk_rsp(ST_TARGET, r_key[0], r_key[1], r_key[2]);
                        r_state <= S_EMIT;
                    end else if (r_rd[1]) begin
                        r_pend  <= mk_rsp(ST_OCCUPIED, r_key[0], r_key[1], r_key[2]);
                        r_state <= S_EMIT;
                    end else if (r_rd == CELL_UNKNOWN && !r_ign) begin
                        r_pend  <= mk_rsp(ST_UNKNOWN, r_key[0], r_key[1], r_key[2]);
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out       <= r_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule
